// File: src/per_cell_pedestal_accumulator_core_assert.svh
// Assertion macros used by the checker of the pedestal accumulator.
`ifndef PER_CELL_PEDESTAL_ACCUMULATOR_CORE_ASSERT_SVH
`define PER_CELL_PEDESTAL_ACCUMULATOR_CORE_ASSERT_SVH

// Check a property on every rising clk edge outside reset.
`define PPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define PPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ppa_pkg.sv
package ppa_pkg;

  localparam int NUM_MODULES       = 2;
  localparam int PIXELS_PER_MODULE = 64;
  localparam int NUM_BLOCKS        = 16;
  localparam int SAMPLES_PER_WAVE  = 32;
  localparam int NUM_PHASES        = 32;
  localparam int FRACTION_BITS     = 8;

  localparam int SLOTS  = NUM_PHASES + SAMPLES_PER_WAVE - 1;
  localparam int CELLS  = NUM_MODULES * PIXELS_PER_MODULE * NUM_BLOCKS * SLOTS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int ADC_W    = 16;
  localparam int SMP_W    = 5;
  localparam int MOD_W    = 1;
  localparam int PIX_W    = 6;
  localparam int BLK_W    = 4;
  localparam int PH_W     = 5;
  localparam int MEAN_W   = 24;
  localparam int CNT_W    = 16;
  localparam int SPREAD_W = 64;
  localparam int STD_W    = 24;
  localparam int WORD_W   = SPREAD_W + CNT_W + MEAN_W;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 64;
  localparam int M_USER_W = 2;

  localparam int DIV_W      = SPREAD_W;
  localparam int DIVISOR_W  = CNT_W;
  localparam int SQRT_STEPS = SPREAD_W / 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // register index, taken from paddr[2]
  localparam logic REG_DIAG = 1'b0;

endpackage

// File: src/ppa_ram.sv
module ppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ppa_div.sv
// Restoring divider, one quotient bit per cycle.
module ppa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ppa_pkg::DIV_W-1:0]      dividend,
  input  logic [ppa_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [ppa_pkg::DIV_W-1:0]      quotient
);
  import ppa_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= STEP_W'(DIV_W - 1);
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        // shift one dividend bit in, one quotient bit out
        if (fits) begin
          rem <= DIVISOR_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DIVISOR_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], fits};
        step     <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/per_cell_pedestal_accumulator_core.sv
// Items run one at a time: a new beat is taken only after the previous result has
// been loaded into the output register. The shared 64-step divider (run once, or twice
// when a std is due in diagnostic mode) and the 32-step square root (run only when a
// std is due) set how long each item takes.
// Reset: synchronous; after reset a clearing pass writes zero to all 129024 cells,
// one cell a cycle, before the first input beat is taken. Config writes work throughout.
module per_cell_pedestal_accumulator_core (
  input  logic                           clk,
  input  logic                           rst,
  // adc_value, sample_index, module_index, pixel_index, block_index, block_phase
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ppa_pkg::S_DATA_W-1:0]   s_tdata,
  // mean_value, hit_count, std_value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ppa_pkg::M_DATA_W-1:0]   m_tdata,
  // std_valid, count_saturated
  output logic [ppa_pkg::M_USER_W-1:0]   m_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ppa_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_DIV1, ST_MUL, ST_SUM,
    ST_DIV2, ST_SQRT, ST_DONE
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  logic diag;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIAG) ? {31'b0, diag} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      diag <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIAG) begin
      diag <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- cell address
  // Clamp each index to its legal range, then linearize:
  // ((module * pixels + pixel) * blocks + block) * slots + phase + sample.
  logic [ADC_W-1:0] in_adc;
  logic [SMP_W-1:0] in_smp;
  logic [MOD_W-1:0] in_mod;
  logic [PIX_W-1:0] in_pix;
  logic [BLK_W-1:0] in_blk;
  logic [PH_W-1:0]  in_ph;
  logic [31:0]      lin;
  logic [ADDR_W-1:0] addr_c;

  always_comb begin
    in_adc = s_tdata[15:0];
    in_smp = (s_tdata[20:16] >= SMP_W'(SAMPLES_PER_WAVE - 1)) ?
             SMP_W'(SAMPLES_PER_WAVE - 1) : s_tdata[20:16];
    in_mod = (s_tdata[21:21] >= MOD_W'(NUM_MODULES - 1)) ?
             MOD_W'(NUM_MODULES - 1) : s_tdata[21:21];
    in_pix = (s_tdata[27:22] >= PIX_W'(PIXELS_PER_MODULE - 1)) ?
             PIX_W'(PIXELS_PER_MODULE - 1) : s_tdata[27:22];
    in_blk = (s_tdata[31:28] >= BLK_W'(NUM_BLOCKS - 1)) ?
             BLK_W'(NUM_BLOCKS - 1) : s_tdata[31:28];
    in_ph  = (s_tdata[36:32] >= PH_W'(NUM_PHASES - 1)) ?
             PH_W'(NUM_PHASES - 1) : s_tdata[36:32];
    lin = ((32'(in_mod) * 32'(PIXELS_PER_MODULE) + 32'(in_pix)) * 32'(NUM_BLOCKS)
          + 32'(in_blk)) * 32'(SLOTS) + 32'(in_ph) + 32'(in_smp);
    addr_c = (lin >= 32'(CELLS)) ? ADDR_W'(CELLS - 1) : lin[ADDR_W-1:0];
  end

  // ---------------------------------------------------------------- cell memory
  // One word per cell: {spread, count, mean}. Items run one at a time and the
  // write-back lands before the next item's read, so no forwarding is needed.
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] clr_addr;

  // per-item registers
  logic [ADDR_W-1:0]   addr;
  logic [MEAN_W-1:0]   a;          // sample in Q16.8
  logic [CNT_W-1:0]    cnt;
  logic                sat;
  logic                neg1;
  logic [MEAN_W-1:0]   m1;
  logic [MEAN_W-1:0]   m2;
  logic [MEAN_W-1:0]   mean_old;
  logic [MEAN_W-1:0]   mean_new;
  logic [SPREAD_W-1:0] spread_old;
  logic [2*MEAN_W-1:0] prod;
  logic                std_ok;

  // square root
  logic [SPREAD_W-1:0]           sq_x;
  logic [SPREAD_W-1:0]           sq_root;
  logic [SPREAD_W-1:0]           sq_bit;
  logic [$clog2(SQRT_STEPS)-1:0] sq_step;

  // read side, valid in ST_CALC
  logic [MEAN_W-1:0]   rd_mean;
  logic [CNT_W-1:0]    rd_cnt;
  logic                sat_c;
  logic [CNT_W-1:0]    cnt_c;
  logic [MEAN_W:0]     d1_c;
  logic [MEAN_W-1:0]   m1_c;

  // after the first divide
  logic [MEAN_W-1:0]   q_c;
  logic [MEAN_W-1:0]   mean_c;
  logic [MEAN_W:0]     d2_c;

  // sum and write-back
  logic [SPREAD_W:0]   sum_full;
  logic [SPREAD_W-1:0] sum_c;
  logic [SPREAD_W-1:0] spread_w;
  logic [SPREAD_W-1:0] sq_trial;

  // divider
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;

  always_comb begin
    rd_mean = rdata[MEAN_W-1:0];
    rd_cnt  = rdata[MEAN_W +: CNT_W];
    sat_c   = rd_cnt == COUNT_MAX;
    cnt_c   = sat_c ? rd_cnt : rd_cnt + 1'b1;
    d1_c    = {1'b0, a} - {1'b0, rd_mean};
    m1_c    = d1_c[MEAN_W] ? MEAN_W'(-d1_c) : d1_c[MEAN_W-1:0];

    // the mean moves toward the sample by at most the deviation: it stays in range
    q_c    = div_q[MEAN_W-1:0];
    mean_c = neg1 ? mean_old - q_c : mean_old + q_c;
    d2_c   = {1'b0, a} - {1'b0, mean_c};

    sum_full = {1'b0, spread_old} + {{(SPREAD_W + 1 - 2*MEAN_W){1'b0}}, prod};
    sum_c    = sum_full[SPREAD_W] ? '1 : sum_full[SPREAD_W-1:0];
    spread_w = diag ? sum_c : spread_old;
    sq_trial = sq_root + sq_bit;
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {{(DIV_W - MEAN_W){1'b0}}, m1_c};
    div_divisor  = cnt_c;
    if (state == ST_CALC) begin
      div_start = 1'b1;
    end else if (state == ST_SUM && diag && cnt >= CNT_W'(2)) begin
      div_start    = 1'b1;
      div_dividend = sum_c;
      div_divisor  = cnt - 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {spread_w, cnt, mean_new};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_SUM: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  ppa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(addr),
    .rdata(rdata)
  );

  ppa_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  assign s_tready = state == ST_IDLE;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken beat; ST_DONE reloads the register itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            addr  <= addr_c;
            a     <= {in_adc, FRACTION_BITS'(0)};
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          // divider starts on this edge with |d1| / count
          cnt        <= cnt_c;
          sat        <= sat_c;
          neg1       <= d1_c[MEAN_W];
          m1         <= m1_c;
          mean_old   <= rd_mean;
          spread_old <= rdata[MEAN_W + CNT_W +: SPREAD_W];
          state      <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_done) begin
            mean_new <= mean_c;
            m2       <= d2_c[MEAN_W] ? MEAN_W'(-d2_c) : d2_c[MEAN_W-1:0];
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= m1 * m2;
          state <= ST_SUM;
        end
        ST_SUM: begin
          // write back this cycle; second divide starts when a std is due
          if (diag && cnt >= CNT_W'(2)) begin
            std_ok <= 1'b1;
            state  <= ST_DIV2;
          end else begin
            std_ok <= 1'b0;
            state  <= ST_DONE;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            sq_x    <= div_q;
            sq_root <= '0;
            sq_bit  <= {2'b01, {(SPREAD_W - 2){1'b0}}};
            sq_step <= '0;
            state   <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_x >= sq_trial) begin
            sq_x    <= sq_x - sq_trial;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit  <= sq_bit >> 2;
          sq_step <= sq_step + 1'b1;
          if (sq_step == $bits(sq_step)'(SQRT_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata[MEAN_W-1:0]        <= mean_new;
            m_tdata[MEAN_W +: CNT_W]   <= cnt;
            if (!std_ok) begin
              m_tdata[MEAN_W + CNT_W +: STD_W] <= '0;
            end else if (sq_root > SPREAD_W'({STD_W{1'b1}})) begin
              m_tdata[MEAN_W + CNT_W +: STD_W] <= '1;
            end else begin
              m_tdata[MEAN_W + CNT_W +: STD_W] <= sq_root[STD_W-1:0];
            end
            m_tuser <= {sat, std_ok};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/ppa_checker.sv
`include "per_cell_pedestal_accumulator_core_assert.svh"

module ppa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [ppa_pkg::M_DATA_W-1:0] m_tdata,
  input logic [ppa_pkg::M_USER_W-1:0] m_tuser
);
  import ppa_pkg::*;

  // one item in flight: no second beat right after an accept
  `PPA_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second beat taken early")

  // a stalled result beat holds
  `PPA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")

  // every result has counted at least one hit
  `PPA_ASSERT(a_count_nz, m_tvalid |-> m_tdata[39:24] != 16'h0, "zero hit count")

  // saturation only at the largest count
  `PPA_ASSERT(a_sat_max, m_tvalid && m_tuser[1] |-> m_tdata[39:24] == 16'hFFFF, "bad saturation")

  // no std without std_valid
  `PPA_ASSERT(a_std_zero, m_tvalid && !m_tuser[0] |-> m_tdata[63:40] == 24'h0, "std without valid")

endmodule

bind per_cell_pedestal_accumulator_core ppa_checker u_ppa_checker (.*);

// File: dv/tb_top.sv
module tb_top;
  import ppa_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // adc_value[15:0], sample_index[20:16], module_index[21], pixel_index[27:22],
  // block_index[31:28], block_phase[36:32], zero fill[39:37]
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // mean_value[23:0], hit_count[39:24], std_value[63:40]
  logic [M_DATA_W-1:0] m_tdata;
  // std_valid[0], count_saturated[1]
  logic [M_USER_W-1:0] m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  localparam logic [2:0] DIAG_ADDR = {REG_DIAG, 2'b00};
  localparam int         STALL_LIMIT = 600000; // covers the post-reset clearing pass
  localparam int         DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  hits;
    logic [STD_W-1:0]  sdev;
    logic              sdev_ok;
    logic              saturated;
  } pedestal_t;

  // Golden per-cell state; a missing key means the cell still holds zero.
  logic [MEAN_W-1:0]   cell_mean[int];
  logic [CNT_W-1:0]    cell_hits[int];
  logic [SPREAD_W-1:0] cell_spread[int];
  logic                diag_on = 1'b0;

  pedestal_t pending_pedestals[$];
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_std_valid = 0;
  int        idle_cycles = 0;
  int        hot_cells[8];

  per_cell_pedestal_accumulator_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root = 0;
    longint unsigned bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Apply one accepted sample to the golden cell state and return its result.
  function automatic pedestal_t update_pedestal(logic [S_DATA_W-1:0] beat);
    pedestal_t       res;
    int              smp, modi, pix, blk, ph, cell_idx;
    longint          sample, avg, dev_old, dev_new;
    longint unsigned hits, spread, prod;
    logic [127:0]    wide;
    smp  = int'(beat[20:16]);
    modi = int'(beat[21]);
    pix  = int'(beat[27:22]);
    blk  = int'(beat[31:28]);
    ph   = int'(beat[36:32]);
    // Clamp out-of-range indices to the last legal value.
    if (smp >= SAMPLES_PER_WAVE) smp = SAMPLES_PER_WAVE - 1;
    if (modi >= NUM_MODULES) modi = NUM_MODULES - 1;
    if (pix >= PIXELS_PER_MODULE) pix = PIXELS_PER_MODULE - 1;
    if (blk >= NUM_BLOCKS) blk = NUM_BLOCKS - 1;
    if (ph >= NUM_PHASES) ph = NUM_PHASES - 1;
    cell_idx = ((modi * PIXELS_PER_MODULE + pix) * NUM_BLOCKS + blk) * SLOTS + ph + smp;
    if (cell_idx >= CELLS) cell_idx = CELLS - 1;

    hits   = cell_hits.exists(cell_idx) ? 64'(cell_hits[cell_idx]) : 64'd0;
    avg    = cell_mean.exists(cell_idx) ? longint'(cell_mean[cell_idx]) : 64'sd0;
    spread = cell_spread.exists(cell_idx) ? cell_spread[cell_idx] : 64'd0;

    res = '0;
    res.saturated = (hits == COUNT_MAX);
    if (!res.saturated) hits++;
    cell_hits[cell_idx] = CNT_W'(hits);

    sample  = longint'(beat[15:0]) <<< FRACTION_BITS;
    dev_old = sample - avg;
    avg     = avg + dev_old / longint'(hits); // truncates toward zero
    cell_mean[cell_idx] = MEAN_W'(avg);

    if (diag_on) begin
      dev_new = sample - avg;
      wide = 128'(dev_old < 0 ? -dev_old : dev_old) * 128'(dev_new < 0 ? -dev_new : dev_new);
      prod = (wide[127:64] != 0) ? '1 : wide[63:0];
      spread = (spread > ~prod) ? '1 : spread + prod;
      cell_spread[cell_idx] = spread;
      if (hits >= 2) begin
        spread = int_sqrt(spread / (hits - 1));
        res.sdev    = (spread > 64'hFF_FFFF) ? '1 : spread[STD_W-1:0];
        res.sdev_ok = 1'b1;
      end
    end
    res.mean = (avg > 64'hFF_FFFF) ? '1 : avg[MEAN_W-1:0];
    res.hits = hits[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic [S_DATA_W-1:0] pack_sample(logic [15:0] adc, logic [4:0] smp,
      logic modi, logic [5:0] pix, logic [3:0] blk, logic [4:0] ph);
    return {3'b000, ph, blk, pix, modi, smp, adc};
  endfunction

  // Present one beat and hold it until the core takes it.
  task automatic send_sample(logic [S_DATA_W-1:0] beat);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    pending_pedestals.push_back(update_pedestal(beat));
    n_sent++;
  endtask

  task automatic hold_off(int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Random burst gaps: mostly none, sometimes a short pause.
  task automatic maybe_gap();
    if ($urandom_range(0, 9) < 2) hold_off($urandom_range(0, 12));
  endtask

  task automatic wait_drained();
    hold_off(0);
    while (pending_pedestals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b0; paddr <= addr; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Change the mode only with the pipeline empty, then read it back.
  task automatic set_diag(logic on);
    logic [31:0] rd;
    wait_drained();
    apb_write(DIAG_ADDR, {31'b0, on});
    diag_on = on;
    apb_read(DIAG_ADDR, rd);
    if (rd[0] !== on) begin
      $error("diagnostic_enable readback: expected %0d actual %0d", on, rd[0]);
      n_errors++;
    end
  endtask

  // Field extremes, then one cell hammered with values near both rails for a wide spread.
  task automatic test_directed();
    send_sample(pack_sample(16'h0000, 5'd0, 1'b0, 6'd0, 4'd0, 5'd0));
    send_sample(pack_sample(16'hFFFF, 5'd31, 1'b1, 6'd63, 4'd15, 5'd31));
    send_sample(pack_sample(16'hFFFF, 5'd0, 1'b0, 6'd0, 4'd0, 5'd0));
    send_sample(pack_sample(16'h0000, 5'd31, 1'b1, 6'd63, 4'd15, 5'd31));
    for (int i = 0; i < 8; i++)
      send_sample(pack_sample(i[0] ? 16'hFFFF : 16'h0001, 5'd3, 1'b1, 6'd21, 4'd9, 5'd7));
    // Same cell reached via a different phase/sample split.
    send_sample(pack_sample(16'h8000, 5'd7, 1'b1, 6'd21, 4'd9, 5'd3));
  endtask

  task automatic test_random(int n_items);
    int          cell_pick;
    logic [15:0] adc;
    for (int i = 0; i < n_items; i++) begin
      maybe_gap();
      case ($urandom_range(0, 3))
        0:       adc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        1:       adc = 16'h4000 + 16'($urandom_range(0, 255));
        default: adc = 16'($urandom);
      endcase
      // Most beats land on a few hot cells so counts and spreads grow.
      if ($urandom_range(0, 9) < 7) begin
        cell_pick = hot_cells[$urandom_range(0, 7)];
        send_sample(pack_sample(adc, cell_pick[4:0], cell_pick[5], cell_pick[11:6],
                                cell_pick[15:12], cell_pick[20:16]));
      end else begin
        send_sample(pack_sample(adc, 5'($urandom), 1'($urandom), 6'($urandom),
                                4'($urandom), 5'($urandom)));
      end
    end
  endtask

  // Check each result beat against the oldest pending prediction.
  always @(posedge clk) begin
    pedestal_t exp_p;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pedestals.size() == 0) begin
        $error("result beat with no pending sample: tdata=%h tuser=%b", m_tdata, m_tuser);
        n_errors++;
      end else begin
        exp_p = pending_pedestals.pop_front();
        n_checked++;
        if (exp_p.sdev_ok) n_std_valid++;
        if (m_tdata[23:0] !== exp_p.mean) begin
          $error("mean_value: expected %0d actual %0d", exp_p.mean, m_tdata[23:0]);
          n_errors++;
        end
        if (m_tdata[39:24] !== exp_p.hits) begin
          $error("hit_count: expected %0d actual %0d", exp_p.hits, m_tdata[39:24]);
          n_errors++;
        end
        if (m_tdata[63:40] !== exp_p.sdev) begin
          $error("std_value: expected %0d actual %0d", exp_p.sdev, m_tdata[63:40]);
          n_errors++;
        end
        if (m_tuser[0] !== exp_p.sdev_ok) begin
          $error("std_valid: expected %0d actual %0d", exp_p.sdev_ok, m_tuser[0]);
          n_errors++;
        end
        if (m_tuser[1] !== exp_p.saturated) begin
          $error("count_saturated: expected %0d actual %0d", exp_p.saturated, m_tuser[1]);
          n_errors++;
        end
      end
    end
  end

  // Receiver stall pattern: long ready stretches alternating with stall runs.
  always @(negedge clk) begin
    int phase_cnt;
    phase_cnt = int'(($time / 10) % 200);
    if (phase_cnt < 60) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** per_cell_pedestal_accumulator_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) hot_cells[i] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Exercise both register settings around the directed set.
    test_directed();
    set_diag(1'b1);
    test_directed();
    test_random(400);
    set_diag(1'b0);
    test_random(200);
    set_diag(1'b1);
    test_random(150);
    // Sender waits for every result before continuing.
    wait_drained();
    test_random(250);
    wait_drained();

    $display("Sent %0d samples, checked %0d results, %0d with a valid deviation.",
             n_sent, n_checked, n_std_valid);
    $display("Covered diagnostic mode off and on, field extremes and hot-cell accumulation.");
    if (n_errors == 0 && pending_pedestals.size() == 0) begin
      $display("** per_cell_pedestal_accumulator_core: PASSED **");
    end else begin
      $display("** per_cell_pedestal_accumulator_core: FAILED **");
    end
    $finish;
  end

endmodule
